### sv/mrr_pkg.sv
// shared types and constants for the miller-rabin round block
package mrr_pkg;
	typedef struct packed {
		logic [1:0] kind;
	} mrr_dummy_t;

	localparam logic [1:0] KIND_COMPOSITE = 2'd0;
	localparam logic [1:0] KIND_PRIME     = 2'd1;
	localparam logic [1:0] KIND_GENERAL   = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_STRIP,
		ST_BASE,
		ST_PINIT,
		ST_PMUL,
		ST_PSQR,
		ST_CHECK,
		ST_SQ,
		ST_SQCHK,
		ST_DONE
	} mrr_state_t;

	typedef enum logic [1:0] {
		MU_IDLE,
		MU_RUN,
		MU_DONE
	} mrr_mu_state_t;
endpackage

### sv/mrr_modmul.sv
// serial modular multiplier and modular remainder unit
module mrr_modmul import mrr_pkg::*; #(
	parameter int WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             rem_mode,
	input  logic [WIDTH-1:0] a,
	input  logic [WIDTH-1:0] b,
	input  logic [WIDTH-1:0] m,
	output logic             done,
	output logic [WIDTH-1:0] r
);
	localparam int CW = $clog2(WIDTH + 1);

	mrr_mu_state_t st_q, st_d;
	logic [CW-1:0]  cnt_q;
	logic [WIDTH-1:0] a_q, b_q, m_q, r_q;
	logic           rem_q;
	logic [WIDTH:0] dred, add1, ared, rsh;
	logic [WIDTH-1:0] step1, step2;

	// doubling step; rem mode shifts in the next bit of b instead of adding a
	always_comb begin
		rsh = {r_q, rem_q ? b_q[WIDTH-1] : 1'b0};
		dred = rsh - {1'b0, m_q};
		step1 = (rsh >= {1'b0, m_q}) ? dred[WIDTH-1:0] : rsh[WIDTH-1:0];
		add1 = {1'b0, step1} + {1'b0, a_q};
		ared = add1 - {1'b0, m_q};
		if (!rem_q && b_q[WIDTH-1])
			step2 = (add1 >= {1'b0, m_q}) ? ared[WIDTH-1:0] : add1[WIDTH-1:0];
		else
			step2 = step1;
	end

	always_comb begin
		st_d = st_q;
		case (st_q)
			MU_IDLE: if (start) st_d = MU_RUN;
			MU_RUN:  if (cnt_q == CW'(1)) st_d = MU_DONE;
			MU_DONE: st_d = MU_IDLE;
			default: st_d = MU_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= MU_IDLE;
			cnt_q <= '0;
		end else begin
			st_q <= st_d;
			if (st_q == MU_IDLE && start) cnt_q <= CW'(WIDTH);
			else if (st_q == MU_RUN) cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == MU_IDLE && start) begin
			a_q   <= a;
			b_q   <= b;
			m_q   <= m;
			rem_q <= rem_mode;
			r_q   <= '0;
		end else if (st_q == MU_RUN) begin
			r_q <= step2;
			b_q <= {b_q[WIDTH-2:0], 1'b0};
		end
	end

	assign done = (st_q == MU_DONE);
	assign r    = r_q;
endmodule

### sv/mrr_front.sv
// front end: accepts beats, classifies small candidates, feeds a two-entry queue
module mrr_front import mrr_pkg::*; #(
	parameter int WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             valid,
	output logic             ready,
	input  logic [WIDTH-1:0] candidate,
	input  logic [WIDTH-1:0] random_value,
	output logic             q_valid,
	input  logic             q_ready,
	output logic [1:0]       q_kind,
	output logic [WIDTH-1:0] q_n,
	output logic [WIDTH-1:0] q_rv
);
	logic [1:0]       kind_q [2];
	logic [WIDTH-1:0] n_q [2];
	logic [WIDTH-1:0] rv_q [2];
	logic [1:0]       cnt_q;
	logic             rd_q, wr_q;
	logic [1:0]       kind;
	logic             push, pop;

	always_comb begin
		if (candidate <= WIDTH'(1) || candidate == WIDTH'(4)) kind = KIND_COMPOSITE;
		else if (candidate <= WIDTH'(3)) kind = KIND_PRIME;
		else kind = KIND_GENERAL;
	end

	assign ready   = (cnt_q != 2'd2);
	assign push    = valid && ready;
	assign q_valid = (cnt_q != 2'd0);
	assign pop     = q_valid && q_ready;
	assign q_kind  = kind_q[rd_q];
	assign q_n     = n_q[rd_q];
	assign q_rv    = rv_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			kind_q[wr_q] <= kind;
			n_q[wr_q]    <= candidate;
			rv_q[wr_q]   <= random_value;
		end
	end
endmodule

### sv/mrr_back.sv
// back end: sequencer for the round using one shared modular unit
module mrr_back import mrr_pkg::*; #(
	parameter int WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	output logic             q_ready,
	input  logic [1:0]       q_kind,
	input  logic [WIDTH-1:0] q_n,
	input  logic [WIDTH-1:0] q_rv,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             out_verdict,
	output logic [WIDTH-1:0] out_base
);
	localparam int SW = $clog2(WIDTH + 1);

	mrr_state_t st_q, st_d;
	logic [WIDTH-1:0] n_q, d_q, a_q, x_q, res_q, rv_q;
	logic [SW-1:0]    s_q, i_q;
	logic             verdict_q, valid_q;
	logic             mu_start, mu_rem, mu_done;
	logic [WIDTH-1:0] mu_a, mu_b, mu_m, mu_r, nm1;

	assign nm1 = n_q - WIDTH'(1);

	mrr_modmul #(.WIDTH(WIDTH)) u_mul (
		.clk(clk), .arst_n(arst_n), .start(mu_start), .rem_mode(mu_rem),
		.a(mu_a), .b(mu_b), .m(mu_m), .done(mu_done), .r(mu_r)
	);

	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE: if (q_valid && !valid_q)
				st_d = (q_kind == KIND_GENERAL) ? ST_STRIP : ST_DONE;
			ST_STRIP: if (d_q[0]) st_d = ST_BASE;
			ST_BASE:  if (mu_done) st_d = ST_PINIT;
			ST_PINIT: st_d = (d_q == '0) ? ST_CHECK : (d_q[0] ? ST_PMUL : ST_PSQR);
			ST_PMUL:  if (mu_done) st_d = ST_PSQR;
			ST_PSQR:  if (mu_done) st_d = ST_PINIT;
			ST_CHECK: st_d = (res_q == WIDTH'(1) || res_q == nm1 || s_q <= SW'(1))
				? ST_DONE : ST_SQ;
			ST_SQ:    if (mu_done) st_d = ST_SQCHK;
			ST_SQCHK: st_d = (x_q == nm1 || x_q == WIDTH'(1) || i_q + SW'(1) >= s_q)
				? ST_DONE : ST_SQ;
			ST_DONE:  st_d = ST_IDLE;
			default:  st_d = ST_IDLE;
		endcase
	end

	always_comb begin
		mu_start = 1'b0;
		mu_rem   = 1'b0;
		mu_a     = a_q;
		mu_b     = x_q;
		mu_m     = n_q;
		case (st_q)
			ST_BASE: begin
				mu_start = 1'b1;
				mu_rem   = 1'b1;
				mu_a     = '0;
				mu_b     = rv_q;
				mu_m     = n_q - WIDTH'(4);
			end
			ST_PINIT: begin
				mu_start = (d_q != '0);
				mu_a     = d_q[0] ? res_q : x_q;
				mu_b     = x_q;
			end
			// the unit only takes start while idle, so holding it here is safe
			ST_PSQR: begin
				mu_start = 1'b1;
				mu_a     = x_q;
				mu_b     = x_q;
			end
			ST_CHECK: begin
				mu_start = !(res_q == WIDTH'(1) || res_q == nm1 || s_q <= SW'(1));
				mu_a     = res_q;
				mu_b     = res_q;
			end
			ST_SQCHK: begin
				mu_start = !(x_q == nm1 || x_q == WIDTH'(1) || i_q + SW'(1) >= s_q);
				mu_a     = x_q;
				mu_b     = x_q;
			end
			default: ;
		endcase
	end

	assign q_ready     = (st_q == ST_IDLE) && !valid_q;
	assign out_valid   = valid_q;
	assign out_verdict = verdict_q;
	assign out_base    = a_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_q == ST_DONE) valid_q <= 1'b1;
			else if (out_ready) valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: if (q_valid && !valid_q) begin
				n_q       <= q_n;
				rv_q      <= q_rv;
				d_q       <= q_n - WIDTH'(1);
				s_q       <= '0;
				a_q       <= '0;
				verdict_q <= (q_kind == KIND_PRIME);
			end
			ST_STRIP: if (!d_q[0]) begin
				d_q <= d_q >> 1;
				s_q <= s_q + SW'(1);
			end
			ST_BASE: if (mu_done) begin
				a_q   <= mu_r + WIDTH'(2);
				x_q   <= mu_r + WIDTH'(2);
				res_q <= WIDTH'(1);
			end
			ST_PMUL: if (mu_done) res_q <= mu_r;
			ST_PSQR: if (mu_done) begin
				x_q <= mu_r;
				d_q <= d_q >> 1;
			end
			ST_CHECK: begin
				x_q       <= res_q;
				i_q       <= SW'(1);
				verdict_q <= (res_q == WIDTH'(1) || res_q == nm1);
			end
			ST_SQ: if (mu_done) x_q <= mu_r;
			ST_SQCHK: begin
				i_q       <= i_q + SW'(1);
				verdict_q <= (x_q == nm1);
			end
			default: ;
		endcase
	end
endmodule

### sv/miller_rabin_round_top.sv
// top level of the miller-rabin round block
//  channel | signals                       | direction
//  in      | valid ready candidate random_value | to block
//  out     | out_valid out_ready verdict witness_base | from block
// one round takes up to 2 * WIDTH + 1 modular products, all done one after another
// by the single bit-serial modular unit in the back end
// special candidates skip the modular unit and go straight to the result
// reset clears the queue and the sequencer; a two-entry queue takes beats while the back works
module miller_rabin_round_top import mrr_pkg::*; #(
	parameter int WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             valid,
	output logic             ready,
	input  logic [WIDTH-1:0] candidate,
	input  logic [WIDTH-1:0] random_value,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             verdict,
	output logic [31:0]      witness_base
);
	logic             q_valid, q_ready;
	logic [1:0]       q_kind;
	logic [WIDTH-1:0] q_n, q_rv, base;

	mrr_front #(.WIDTH(WIDTH)) u_front (
		.clk(clk), .arst_n(arst_n), .valid(valid), .ready(ready),
		.candidate(candidate), .random_value(random_value),
		.q_valid(q_valid), .q_ready(q_ready), .q_kind(q_kind), .q_n(q_n), .q_rv(q_rv)
	);

	mrr_back #(.WIDTH(WIDTH)) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_ready(q_ready),
		.q_kind(q_kind), .q_n(q_n), .q_rv(q_rv), .out_valid(out_valid),
		.out_ready(out_ready), .out_verdict(verdict), .out_base(base)
	);

	assign witness_base = 32'(base);

`ifndef ASSERT_OFF
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(verdict))
		else $error("result changed while stalled");
	a_q_ready: assert property (@(posedge clk) disable iff (!arst_n)
		q_ready |-> !out_valid)
		else $error("back took work with a result pending");
`endif
endmodule
